// ----- src/ilsu_pkg.sv -----
package ilsu_pkg;

	localparam int unsigned FUNC_W   = 3;
	localparam int unsigned POS_W    = 9;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned FPOS_W   = 8;
	localparam int unsigned COUNT_W  = 9;

	typedef enum logic [FUNC_W-1:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_FIND   = 3'd2,
		OP_READ   = 3'd3,
		OP_WRITE  = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_FULL   = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_INS_SHIFT,
		S_INS_PUT,
		S_DEL_SHIFT,
		S_FIND,
		S_RD_WAIT,
		S_RESP
	} state_t;

endpackage

// ----- src/ilsu_ram.sv -----
module ilsu_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/indexed_list_store_unit.sv -----
// write, errors and bad ops go from decode to the response state; read passes a wait state for ram data
// insert shifts the tail up from count down to position, then puts the value; delete shifts it down
// find walks until the first hit or the end; the ram port pair walking the list sets the time per beat
// one beat in flight at a time; a new beat is taken while the previous result waits to be taken
// async active-low reset clears the count, the sequencer and output valid; ram contents stay
module indexed_list_store_unit #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [ilsu_pkg::FUNC_W-1:0]         func,
	input  logic [ilsu_pkg::POS_W-1:0]          position,
	input  logic signed [ilsu_pkg::VAL_W-1:0]   value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ilsu_pkg::STAT_W-1:0]         status,
	output logic signed [ilsu_pkg::VAL_W-1:0]   read_value,
	output logic                                found,
	output logic [ilsu_pkg::FPOS_W-1:0]         found_position,
	output logic [ilsu_pkg::COUNT_W-1:0]        count
);
	import ilsu_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

	state_t state_q, state_d;

	logic [FUNC_W-1:0] func_q;
	logic [POS_W-1:0]  pos_q;
	logic [VAL_W-1:0]  val_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     i_q, i_d, i_dec, i_inc;
	logic [AW-1:0]     dst_q, dst_d;
	logic              pend_q, pend_d;

	logic [STAT_W-1:0] res_status_q;
	logic [VAL_W-1:0]  res_rd_q;
	logic              res_found_q;
	logic [FPOS_W-1:0] res_fpos_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [VAL_W-1:0]  out_rd_q;
	logic              out_found_q;
	logic [FPOS_W-1:0] out_fpos_q;
	logic [COUNT_W-1:0] out_count_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [VAL_W-1:0]  mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [VAL_W-1:0]  rd_data;

	logic [XW-1:0]     pos_x, cnt_x, i_x, dst_x;
	logic              pos_gt_cnt, pos_ge_cnt, is_full, more_ins, more_walk, hit, resp_go;
	logic [STAT_W-1:0] dec_status;

	assign pos_x      = XW'(pos_q);
	assign cnt_x      = XW'(cnt_q);
	assign i_x        = XW'(i_q);
	assign dst_x      = XW'(dst_q);
	assign i_dec      = i_q - CW'(1);
	assign i_inc      = i_q + CW'(1);
	assign pos_gt_cnt = pos_x > cnt_x;
	assign pos_ge_cnt = pos_x >= cnt_x;
	assign is_full    = cnt_q == CW'(DEPTH);
	assign more_ins   = i_x > pos_x;
	assign more_walk  = i_q < cnt_q;
	assign hit        = pend_q && (rd_data == val_q);
	assign resp_go    = !out_valid_q || out_ready;

	ilsu_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	always_comb begin
		unique case (func_q)
			OP_INSERT: begin
				if (pos_gt_cnt) begin
					dec_status = STAT_BADPOS;
				end else if (is_full) begin
					dec_status = STAT_FULL;
				end else begin
					dec_status = STAT_OK;
				end
			end
			OP_DELETE, OP_READ, OP_WRITE: dec_status = pos_ge_cnt ? STAT_BADPOS : STAT_OK;
			OP_FIND: dec_status = STAT_OK;
			default: dec_status = STAT_BADPOS;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (func_q)
					OP_INSERT: state_d = (dec_status == STAT_OK) ? S_INS_SHIFT : S_RESP;
					OP_DELETE: state_d = (dec_status == STAT_OK) ? S_DEL_SHIFT : S_RESP;
					OP_FIND:   state_d = S_FIND;
					OP_READ:   state_d = (dec_status == STAT_OK) ? S_RD_WAIT : S_RESP;
					default:   state_d = S_RESP;
				endcase
			end
			S_INS_SHIFT: begin
				if (!more_ins) begin
					state_d = S_INS_PUT;
				end
			end
			S_INS_PUT: state_d = S_RESP;
			S_DEL_SHIFT: begin
				if (!more_walk) begin
					state_d = S_RESP;
				end
			end
			S_FIND: begin
				if (hit || !more_walk) begin
					state_d = S_RESP;
				end
			end
			S_RD_WAIT: state_d = S_RESP;
			S_RESP: begin
				if (resp_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = state_q == S_IDLE;
		mem_we    = 1'b0;
		mem_waddr = dst_q;
		mem_wdata = rd_data;
		mem_raddr = i_q[AW-1:0];
		i_d       = i_q;
		dst_d     = dst_q;
		pend_d    = 1'b0;
		unique case (state_q)
			S_DECODE: begin
				mem_raddr = pos_x[AW-1:0];
				mem_waddr = pos_x[AW-1:0];
				mem_wdata = val_q;
				mem_we    = (func_q == OP_WRITE) && (dec_status == STAT_OK);
				unique case (func_q)
					OP_INSERT: i_d = cnt_q;
					OP_DELETE: i_d = pos_x[CW-1:0] + CW'(1);
					default:   i_d = '0;
				endcase
			end
			S_INS_SHIFT: begin
				mem_we    = pend_q;
				mem_raddr = i_dec[AW-1:0];
				if (more_ins) begin
					pend_d = 1'b1;
					dst_d  = i_q[AW-1:0];
					i_d    = i_dec;
				end
			end
			S_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = pos_x[AW-1:0];
				mem_wdata = val_q;
			end
			S_DEL_SHIFT: begin
				mem_we = pend_q;
				if (more_walk) begin
					pend_d = 1'b1;
					dst_d  = i_dec[AW-1:0];
					i_d    = i_inc;
				end
			end
			S_FIND: begin
				if (more_walk) begin
					pend_d = 1'b1;
					dst_d  = i_q[AW-1:0];
					i_d    = i_inc;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			if (state_q == S_INS_PUT) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (state_q == S_DEL_SHIFT && !more_walk) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (state_q == S_RESP && resp_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q   <= i_d;
		dst_q <= dst_d;
		if (state_q == S_IDLE && in_valid) begin
			func_q <= func;
			pos_q  <= position;
			val_q  <= value;
		end
		unique case (state_q)
			S_DECODE: begin
				res_status_q <= dec_status;
				res_rd_q     <= '0;
				res_found_q  <= 1'b0;
				res_fpos_q   <= '0;
			end
			S_RD_WAIT: res_rd_q <= rd_data;
			S_FIND: begin
				if (hit) begin
					res_found_q <= 1'b1;
					res_fpos_q  <= dst_x[FPOS_W-1:0];
				end
			end
			default: begin
			end
		endcase
		if (state_q == S_RESP && resp_go) begin
			out_status_q <= res_status_q;
			out_rd_q     <= res_rd_q;
			out_found_q  <= res_found_q;
			out_fpos_q   <= res_fpos_q;
			out_count_q  <= cnt_x[COUNT_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign read_value     = out_rd_q;
	assign found          = out_found_q;
	assign found_position = out_fpos_q;
	assign count          = out_count_q;

endmodule

// ----- bench/ilsu_checker.sv -----
`timescale 1ns / 100ps

module ilsu_checker #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [ilsu_pkg::FUNC_W-1:0]         func,
	input  logic [ilsu_pkg::POS_W-1:0]          position,
	input  logic signed [ilsu_pkg::VAL_W-1:0]   value,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [ilsu_pkg::STAT_W-1:0]         status,
	input  logic signed [ilsu_pkg::VAL_W-1:0]   read_value,
	input  logic                                found,
	input  logic [ilsu_pkg::FPOS_W-1:0]         found_position,
	input  logic [ilsu_pkg::COUNT_W-1:0]        count,
	output int                                  mismatches,
	output int                                  outstanding
);
	import ilsu_pkg::*;

	typedef struct {
		stat_t               status;
		logic [VAL_W-1:0]    read_value;
		logic                found;
		logic [FPOS_W-1:0]   found_position;
		logic [COUNT_W-1:0]  count;
	} list_reply_t;

	logic [VAL_W-1:0] list_mem [DEPTH];
	int list_len = 0;
	list_reply_t replies_due [$];
	int fails = 0;

	assign mismatches = fails;

	function automatic list_reply_t apply_list_op(input logic [FUNC_W-1:0] f,
			input logic [POS_W-1:0] p, input logic [VAL_W-1:0] v);
		list_reply_t r;
		int i;
		r.status = STAT_OK;
		r.read_value = '0;
		r.found = 1'b0;
		r.found_position = '0;
		case (f)
			OP_INSERT: begin
				if (int'(p) > list_len) begin
					r.status = STAT_BADPOS;
				end else if (list_len >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					for (i = list_len; i > int'(p); i--)
						list_mem[i] = list_mem[i - 1];
					list_mem[p] = v;
					list_len++;
				end
			end
			OP_DELETE: begin
				if (int'(p) >= list_len) begin
					r.status = STAT_BADPOS;
				end else begin
					for (i = int'(p); i + 1 < list_len; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
				end
			end
			OP_FIND: begin
				for (i = 0; i < list_len; i++) begin
					if (!r.found && list_mem[i] == v) begin
						r.found = 1'b1;
						r.found_position = i[FPOS_W-1:0];
					end
				end
			end
			OP_READ: begin
				if (int'(p) >= list_len)
					r.status = STAT_BADPOS;
				else
					r.read_value = list_mem[p];
			end
			OP_WRITE: begin
				if (int'(p) >= list_len)
					r.status = STAT_BADPOS;
				else
					list_mem[p] = v;
			end
			default: begin
				r.status = STAT_BADPOS;
			end
		endcase
		r.count = list_len[COUNT_W-1:0];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] got);
		if (got !== want) begin
			$error("%s expected %0h got %0h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk) begin : watch_beats
		list_reply_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					$error("result beat with no operation pending");
					fails++;
				end else begin
					want = replies_due.pop_front();
					check_field("status", VAL_W'(want.status), VAL_W'(status));
					check_field("read_value", want.read_value, read_value);
					check_field("found", VAL_W'(want.found), VAL_W'(found));
					check_field("found_position", VAL_W'(want.found_position),
						VAL_W'(found_position));
					check_field("count", VAL_W'(want.count), VAL_W'(count));
				end
			end
			if (in_valid && in_ready)
				replies_due.push_back(apply_list_op(func, position, value));
		end
		outstanding <= replies_due.size();
	end

endmodule

// ----- bench/indexed_list_store_unit_test.sv -----
`timescale 1ns / 100ps

module indexed_list_store_unit_test;
	import ilsu_pkg::*;

	localparam int unsigned DEPTH = 256;
	localparam int PHASE_BEATS = 200;
	localparam longint unsigned CYCLE_LIMIT = 2_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [FUNC_W-1:0] func = '0;
	logic [POS_W-1:0] position = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STAT_W-1:0] status;
	logic signed [VAL_W-1:0] read_value;
	logic found;
	logic [FPOS_W-1:0] found_position;
	logic [COUNT_W-1:0] count;

	int bad_beats;
	int beats_owed;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int fill_level = 0;
	logic [VAL_W-1:0] value_pool [16];
	longint unsigned cycles = 0;

	indexed_list_store_unit #(.DEPTH(DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .position(position), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .read_value(read_value), .found(found),
		.found_position(found_position), .count(count)
	);

	ilsu_checker #(.DEPTH(DEPTH)) u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .position(position), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .read_value(read_value), .found(found),
		.found_position(found_position), .count(count),
		.mismatches(bad_beats), .outstanding(beats_owed)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[indexed_list_store_unit] ERROR");
			$finish;
		end
	end

	// result side, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= 400;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [VAL_W-1:0] pick_value();
		if ($urandom_range(9) < 4)
			return value_pool[$urandom_range(15)];
		return $urandom();
	endfunction

	function automatic logic [POS_W-1:0] pick_pos(input logic [FUNC_W-1:0] f);
		int top_ok;
		int r;
		top_ok = (f == OP_INSERT) ? fill_level : fill_level - 1;
		r = $urandom_range(99);
		if (top_ok < 0 || r < 10)
			return POS_W'($urandom_range(511));
		if (r < 18)
			return POS_W'(top_ok);
		if (r < 24)
			return '0;
		return POS_W'($urandom_range(top_ok));
	endfunction

	task automatic send_beat(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
			input logic [VAL_W-1:0] v);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		func <= f;
		position <= p;
		value <= v;
		do @(posedge clk); while (!in_ready);
		if (f == OP_INSERT && p <= fill_level && fill_level < DEPTH)
			fill_level++;
		else if (f == OP_DELETE && p < fill_level)
			fill_level--;
		if ((f == OP_INSERT || f == OP_WRITE) && $urandom_range(3) == 0)
			value_pool[$urandom_range(15)] = v;
	endtask

	task automatic random_beat(input int ins_w, input int del_w);
		int r;
		logic [FUNC_W-1:0] f;
		r = $urandom_range(99);
		if (r < 3) begin
			f = FUNC_W'($urandom_range(7, 5));
		end else if (r < 3 + ins_w) begin
			f = OP_INSERT;
		end else if (r < 3 + ins_w + del_w) begin
			f = OP_DELETE;
		end else begin
			case (r % 3)
				0: f = OP_FIND;
				1: f = OP_READ;
				default: f = OP_WRITE;
			endcase
		end
		send_beat(f, pick_pos(f), pick_value());
	endtask

	initial begin
		for (int i = 0; i < 16; i++)
			value_pool[i] = $urandom();
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		value_pool[2] = 32'h8000_0000;
		value_pool[3] = 32'h7FFF_FFFF;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list
		send_beat(OP_READ, '0, '0);
		send_beat(OP_DELETE, '0, '0);
		send_beat(OP_FIND, '0, '0);
		send_beat(OP_WRITE, '0, 32'h1234_5678);
		send_beat(OP_INSERT, 9'd1, 32'h1111_1111);
		// build a short list with a duplicate
		send_beat(OP_INSERT, '0, 32'h8000_0000);
		send_beat(OP_INSERT, 9'd1, 32'h7FFF_FFFF);
		send_beat(OP_INSERT, '0, 32'hFFFF_FFFF);
		send_beat(OP_INSERT, 9'd3, 32'h0000_0000);
		send_beat(OP_INSERT, 9'd2, 32'h7FFF_FFFF);
		send_beat(OP_FIND, '0, 32'h7FFF_FFFF);
		send_beat(OP_FIND, 9'd511, 32'h1234_5678);
		send_beat(OP_FIND, '0, 32'h0000_0000);
		send_beat(OP_READ, '0, '0);
		send_beat(OP_READ, 9'd4, '0);
		send_beat(OP_READ, 9'd5, '0);
		send_beat(OP_WRITE, 9'd4, 32'h5555_5555);
		send_beat(OP_WRITE, 9'd5, 32'hAAAA_AAAA);
		send_beat(OP_DELETE, '0, '0);
		send_beat(OP_DELETE, 9'd3, '0);
		send_beat(OP_DELETE, 9'd3, '0);
		send_beat(3'd5, '0, '0);
		send_beat(3'd6, 9'd511, 32'hFFFF_FFFF);
		send_beat(3'd7, 9'd256, 32'h8000_0000);
		send_beat(OP_READ, 9'd511, '0);
		send_beat(OP_INSERT, 9'd256, 32'h0F0F_0F0F);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct <= 0; end
				1: begin send_idle_pct = 47; recv_stall_pct <= 0; end
				2: begin send_idle_pct = 0; recv_stall_pct <= 47; end
				default: begin send_idle_pct = 27; recv_stall_pct <= 27; end
			endcase
			if (ph == 0 || ph == 2)
				hold_reqs <= hold_reqs + 1;
			if (ph == 1) begin
				// fill to the top, then poke the full list
				while (fill_level < DEPTH)
					send_beat(OP_INSERT, POS_W'($urandom_range(fill_level)), pick_value());
				send_beat(OP_INSERT, POS_W'(DEPTH), pick_value());
				send_beat(OP_INSERT, '0, pick_value());
				send_beat(OP_INSERT, POS_W'(DEPTH + 1), pick_value());
				send_beat(OP_INSERT, '1, pick_value());
				send_beat(OP_READ, POS_W'(DEPTH - 1), '0);
				send_beat(OP_WRITE, POS_W'(DEPTH - 1), pick_value());
				send_beat(OP_READ, POS_W'(DEPTH), '0);
				send_beat(OP_FIND, '0, value_pool[$urandom_range(15)]);
				send_beat(OP_DELETE, POS_W'(DEPTH - 1), '0);
			end
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (n < PHASE_BEATS / 2)
					random_beat(55, 15);
				else
					random_beat(15, 55);
			end
			if (ph == 3) begin
				while (fill_level > 0)
					send_beat(OP_DELETE, POS_W'($urandom_range(fill_level - 1)), pick_value());
				send_beat(OP_FIND, '0, value_pool[0]);
				send_beat(OP_INSERT, '0, pick_value());
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		do @(posedge clk); while (beats_owed != 0);
		repeat (DEPTH + 8) @(posedge clk);
		if (bad_beats == 0)
			$display("[indexed_list_store_unit] OK");
		else
			$display("[indexed_list_store_unit] ERROR");
		$finish;
	end

endmodule
